// ===== src/char_stream_tokenizer_defines.svh =====
// assertion macros used by the checker file of the tokenizer
// no dependencies; included by name from the checker
`ifndef CHAR_STREAM_TOKENIZER_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_DEFINES_SVH

// antecedent and consequent in the same cycle
`define CST_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// consequent in the cycle after the antecedent
`define CST_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ===== src/cst_pkg.sv =====
// shared types and codes for the character stream tokenizer
// used by the scanner, the result queue, the top level and the checker
`default_nettype none

package cst_pkg;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_IDX_W = 2;
  localparam int RQ_CNT_W = 3;

  localparam logic [4:0] KIND_LPAREN = 5'd0;
  localparam logic [4:0] KIND_RPAREN = 5'd1;
  localparam logic [4:0] KIND_PLUS   = 5'd2;
  localparam logic [4:0] KIND_MINUS  = 5'd3;
  localparam logic [4:0] KIND_STAR   = 5'd4;
  localparam logic [4:0] KIND_LBRACE = 5'd5;
  localparam logic [4:0] KIND_RBRACE = 5'd6;
  localparam logic [4:0] KIND_COMMA  = 5'd7;
  localparam logic [4:0] KIND_SLASH  = 5'd8;
  localparam logic [4:0] KIND_ASSIGN = 5'd9;
  localparam logic [4:0] KIND_AND    = 5'd10;
  localparam logic [4:0] KIND_OR     = 5'd11;
  localparam logic [4:0] KIND_NE     = 5'd12;
  localparam logic [4:0] KIND_CARET  = 5'd13;
  localparam logic [4:0] KIND_LT     = 5'd14;
  localparam logic [4:0] KIND_GT     = 5'd15;
  localparam logic [4:0] KIND_STRING = 5'd16;
  localparam logic [4:0] KIND_NUMBER = 5'd17;
  localparam logic [4:0] KIND_EOF    = 5'd18;
  localparam logic [4:0] KIND_ERROR  = 5'd19;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_AMP        = 3'd1;
  localparam logic [2:0] ERR_BAR        = 3'd2;
  localparam logic [2:0] ERR_BANG       = 3'd3;
  localparam logic [2:0] ERR_OPEN_STR   = 3'd4;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd5;

  typedef struct packed {
    logic [4:0] token_kind;
    logic       has_byte;
    logic [7:0] text_byte;
    logic       token_end;
    logic [2:0] error_code;
    logic       last_result;
  } result_t;

  // results of one input transaction, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } scan_out_t;

endpackage

`default_nettype wire

// ===== src/cst_scan.sv =====
// scanner: mode register and the decode of one byte or end marker
// into up to two results; depends on cst_pkg
`default_nettype none

module cst_scan import cst_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire logic [7:0] char_in,
  input  wire logic      end_of_text,
  output scan_out_t      scan_out
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_NUMBER = 3'd1;
  localparam logic [2:0] MODE_STRING = 3'd2;
  localparam logic [2:0] MODE_AMP    = 3'd3;
  localparam logic [2:0] MODE_BAR    = 3'd4;
  localparam logic [2:0] MODE_BANG   = 3'd5;
  localparam logic [2:0] MODE_DROP   = 3'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic       hit;
    result_t    res;
    logic [2:0] mode;
  } idle_scan_t;

  logic [2:0] scan_mode;
  logic [2:0] scan_mode_next;
  idle_scan_t idle;
  logic       is_digit;

  function automatic result_t mk(input logic [4:0] kind, input logic has,
                                 input logic [7:0] b, input logic fin,
                                 input logic [2:0] err);
    result_t r;
    r.token_kind  = kind;
    r.has_byte    = has;
    r.text_byte   = b;
    r.token_end   = fin;
    r.error_code  = err;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic idle_scan_t scan_idle(input logic [7:0] c);
    idle_scan_t s;
    s.hit  = 1'b1;
    s.mode = MODE_IDLE;
    s.res  = mk(KIND_ERROR, 1'b0, 8'h00, 1'b1, ERR_NONE);
    case (c)
      8'h28: s.res.token_kind = KIND_LPAREN;
      8'h29: s.res.token_kind = KIND_RPAREN;
      8'h2b: s.res.token_kind = KIND_PLUS;
      8'h2d: s.res.token_kind = KIND_MINUS;
      8'h2a: s.res.token_kind = KIND_STAR;
      8'h7b: s.res.token_kind = KIND_LBRACE;
      8'h7d: s.res.token_kind = KIND_RBRACE;
      8'h2c: s.res.token_kind = KIND_COMMA;
      8'h2f: s.res.token_kind = KIND_SLASH;
      8'h3d: s.res.token_kind = KIND_ASSIGN;
      8'h5e: s.res.token_kind = KIND_CARET;
      8'h3c: s.res.token_kind = KIND_LT;
      8'h3e: s.res.token_kind = KIND_GT;
      CH_SPACE, CH_NL: s.hit = 1'b0;
      CH_AMP: begin
        s.hit  = 1'b0;
        s.mode = MODE_AMP;
      end
      CH_BAR: begin
        s.hit  = 1'b0;
        s.mode = MODE_BAR;
      end
      CH_BANG: begin
        s.hit  = 1'b0;
        s.mode = MODE_BANG;
      end
      CH_QUOTE: begin
        s.hit  = 1'b0;
        s.mode = MODE_STRING;
      end
      default: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          s.mode = MODE_NUMBER;
          s.res  = mk(KIND_NUMBER, 1'b1, c, 1'b0, ERR_NONE);
        end else begin
          s.mode = MODE_DROP;
          s.res  = mk(KIND_ERROR, 1'b0, 8'h00, 1'b1, ERR_UNEXPECTED);
        end
      end
    endcase
    return s;
  endfunction

  assign idle     = scan_idle(char_in);
  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);

  always_comb begin
    scan_mode_next  = scan_mode;
    scan_out.count  = 2'd0;
    scan_out.first  = mk(KIND_EOF, 1'b0, 8'h00, 1'b1, ERR_NONE);
    scan_out.second = mk(KIND_EOF, 1'b0, 8'h00, 1'b1, ERR_NONE);
    if (end_of_text) begin
      scan_mode_next = MODE_IDLE;
      scan_out.count = 2'd2;
      unique case (scan_mode)
        MODE_NUMBER: scan_out.first = mk(KIND_NUMBER, 1'b0, 8'h00, 1'b1, ERR_NONE);
        MODE_STRING: scan_out.first = mk(KIND_ERROR, 1'b0, 8'h00, 1'b1, ERR_OPEN_STR);
        MODE_AMP:    scan_out.first = mk(KIND_ERROR, 1'b0, 8'h00, 1'b1, ERR_AMP);
        MODE_BAR:    scan_out.first = mk(KIND_ERROR, 1'b0, 8'h00, 1'b1, ERR_BAR);
        MODE_BANG:   scan_out.first = mk(KIND_ERROR, 1'b0, 8'h00, 1'b1, ERR_BANG);
        default:     scan_out.count = 2'd1;
      endcase
    end else begin
      unique case (scan_mode)
        MODE_IDLE: begin
          scan_mode_next = idle.mode;
          scan_out.first = idle.res;
          scan_out.count = idle.hit ? 2'd1 : 2'd0;
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            scan_out.first = mk(KIND_NUMBER, 1'b1, char_in, 1'b0, ERR_NONE);
            scan_out.count = 2'd1;
          end else begin
            // close the number, then treat the byte as if idle
            scan_out.first  = mk(KIND_NUMBER, 1'b0, 8'h00, 1'b1, ERR_NONE);
            scan_out.second = idle.res;
            scan_out.count  = idle.hit ? 2'd2 : 2'd1;
            scan_mode_next  = idle.mode;
          end
        end
        MODE_STRING: begin
          scan_out.count = 2'd1;
          if (char_in == CH_QUOTE) begin
            scan_out.first = mk(KIND_STRING, 1'b0, 8'h00, 1'b1, ERR_NONE);
            scan_mode_next = MODE_IDLE;
          end else begin
            scan_out.first = mk(KIND_STRING, 1'b1, char_in, 1'b0, ERR_NONE);
          end
        end
        MODE_AMP: begin
          scan_out.count = 2'd1;
          if (char_in == CH_AMP) begin
            scan_out.first = mk(KIND_AND, 1'b0, 8'h00, 1'b1, ERR_NONE);
            scan_mode_next = MODE_IDLE;
          end else begin
            scan_out.first = mk(KIND_ERROR, 1'b0, 8'h00, 1'b1, ERR_AMP);
            scan_mode_next = MODE_DROP;
          end
        end
        MODE_BAR: begin
          scan_out.count = 2'd1;
          if (char_in == CH_BAR) begin
            scan_out.first = mk(KIND_OR, 1'b0, 8'h00, 1'b1, ERR_NONE);
            scan_mode_next = MODE_IDLE;
          end else begin
            scan_out.first = mk(KIND_ERROR, 1'b0, 8'h00, 1'b1, ERR_BAR);
            scan_mode_next = MODE_DROP;
          end
        end
        MODE_BANG: begin
          scan_out.count = 2'd1;
          if (char_in == CH_EQ) begin
            scan_out.first = mk(KIND_NE, 1'b0, 8'h00, 1'b1, ERR_NONE);
            scan_mode_next = MODE_IDLE;
          end else begin
            scan_out.first = mk(KIND_ERROR, 1'b0, 8'h00, 1'b1, ERR_BANG);
            scan_mode_next = MODE_DROP;
          end
        end
        default: scan_mode_next = MODE_DROP;
      endcase
    end
    // mark the final result of this transaction
    if (scan_out.count == 2'd1) begin
      scan_out.first.last_result = 1'b1;
    end
    if (scan_out.count == 2'd2) begin
      scan_out.second.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_IDLE;
    end else if (accept) begin
      scan_mode <= scan_mode_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/cst_result_queue.sv =====
// four-entry result queue: takes up to two results per cycle,
// hands out one per output transaction; depends on cst_pkg
`default_nettype none

module cst_result_queue import cst_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  scan_out_t      scan_out,
  input  wire logic      pop,
  output logic           nearly_full,
  output logic           not_empty,
  output result_t        head
);

  result_t               entries [RQ_DEPTH];
  logic [RQ_IDX_W-1:0]   wptr;
  logic [RQ_IDX_W-1:0]   rptr;
  logic [RQ_CNT_W-1:0]   count;
  logic [1:0]            push_cnt;
  logic [RQ_IDX_W-1:0]   wptr_inc;

  assign push_cnt    = push ? scan_out.count : 2'd0;
  assign wptr_inc    = wptr + RQ_IDX_W'(1);
  assign not_empty   = (count != '0);
  // room for two more results is needed before the next transaction
  assign nearly_full = (count > RQ_CNT_W'(RQ_DEPTH - 2));
  assign head        = entries[rptr];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[wptr] <= scan_out.first;
    end
    if (push_cnt == 2'd2) begin
      entries[wptr_inc] <= scan_out.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + RQ_IDX_W'(push_cnt);
      rptr  <= rptr + RQ_IDX_W'(pop);
      count <= count + RQ_CNT_W'(push_cnt) - RQ_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/char_stream_tokenizer.sv =====
// Character stream tokenizer. Takes one text byte (or an end-of-text mark)
// per transaction on the char channel and emits tokens on the token channel.
// A byte is decoded in the cycle it is accepted and its zero, one or two
// results land in a four-entry result queue; if the queue was empty, the first
// result is shown on the token ports the next cycle. One input transaction
// is taken per cycle while the queue holds at most two results, so with no
// token stall the sustained rate is one byte per cycle; the output side, one
// result per cycle, sets the limit when two-result bytes arrive back to back.
// Depends on cst_pkg, cst_scan and cst_result_queue.
`default_nettype none

module char_stream_tokenizer import cst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       end_of_text,
  output logic            token_valid,
  input  wire logic       token_stall,
  output logic [4:0]      token_kind,
  output logic            has_byte,
  output logic [7:0]      text_byte,
  output logic            token_end,
  output logic [2:0]      error_code,
  output logic            last_result
);

  logic      accept;
  logic      pop;
  logic      nearly_full;
  scan_out_t scan_out;
  result_t   head;

  assign char_stall = nearly_full;
  assign accept     = char_valid && !char_stall;
  assign pop        = token_valid && !token_stall;

  cst_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_in     (char_in),
    .end_of_text (end_of_text),
    .scan_out    (scan_out)
  );

  cst_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .scan_out    (scan_out),
    .pop         (pop),
    .nearly_full (nearly_full),
    .not_empty   (token_valid),
    .head        (head)
  );

  assign token_kind  = head.token_kind;
  assign has_byte    = head.has_byte;
  assign text_byte   = head.text_byte;
  assign token_end   = head.token_end;
  assign error_code  = head.error_code;
  assign last_result = head.last_result;

endmodule

`default_nettype wire

// ===== src/cst_checker.sv =====
// port-level checks on the tokenizer char and token channels, bound to the top level
// depends on cst_pkg and char_stream_tokenizer_defines.svh
`default_nettype none
`include "char_stream_tokenizer_defines.svh"

module cst_checker import cst_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       char_stall,
  input wire logic       token_valid,
  input wire logic       token_stall,
  input wire logic [4:0] token_kind,
  input wire logic       has_byte,
  input wire logic       token_end,
  input wire logic [2:0] error_code,
  input wire logic       last_result
);

  // a stalled transaction stays offered
  `CST_ASSERT_NEXT(a_hold_valid, clk, rst, token_valid && token_stall, token_valid)
  // error codes only travel on error tokens
  `CST_ASSERT_SAME(a_err_kind, clk, rst, token_valid && error_code != ERR_NONE,
    token_kind == KIND_ERROR)
  // a content byte never closes its token
  `CST_ASSERT_SAME(a_byte_open, clk, rst, token_valid && has_byte, !token_end)
  // end of file is always the closing result of its transaction
  `CST_ASSERT_SAME(a_eof_last, clk, rst, token_valid && token_kind == KIND_EOF,
    last_result && token_end)
  // an empty queue always has room for the next char transaction
  `CST_ASSERT_SAME(a_room_when_empty, clk, rst, !token_valid, !char_stall)

endmodule

bind char_stream_tokenizer cst_checker u_cst_checker (.*);

`default_nettype wire
